FILE: rtl/aldc_pkg.sv
// Package for the audio low-pass / DC-blocker chain.
// Holds the sequencer state type, register indexes and fixed constants.
// No dependencies.
package aldc_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_CENTER     = 2'd2;

    localparam int LP_ALPHA_W = 9;
    localparam int HP_ALPHA_W = 8;

    localparam logic [LP_ALPHA_W-1:0] LP_ALPHA_RESET = 9'd180;
    localparam logic [LP_ALPHA_W-1:0] LP_ALPHA_UNITY = 9'd256;
    localparam logic [HP_ALPHA_W-1:0] HP_ALPHA_RESET = 8'd252;

    // The last step index of each serial multiply (MSB first).
    localparam logic [3:0] LP_LAST_STEP = 4'd8;
    localparam logic [3:0] HP_LAST_STEP = 4'd7;

    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LP_MUL,
        ST_HP_SUM,
        ST_HP_MUL,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/audio_lowpass_dcblock_chain_core.sv
// Top level of the audio low-pass / DC-blocker chain.
// Depends on aldc_pkg.
//
// Usage: each request on the s_ channel carries one raw ADC sample and a
// restart flag. Restart reloads the low-pass accumulator with the midpoint
// shifted left by 8 and clears the DC-blocker history before the sample is
// filtered. Each sample produces two requests on the m_ channel: the low
// byte of the saturated signed 16-bit result, then the high byte with
// m_last set.
// Both filter multiplies run bit-serially, one multiplier bit per cycle. The
// sequencer steps through the low-pass mix, the high-pass difference, the
// high-pass gain and the hand-over of the word, and takes a new sample only
// once the last one has been handed to the output register.
// The finished word sits in an output register, so the next sample is
// accepted while both bytes are still waiting; if the receiver stalls for
// longer, the sequencer holds its finished result until the register frees.
// Configuration writes use cfg_wr_en / cfg_index / cfg_wdata. The user must
// make them only while the block is idle; the block does not check it. Reset
// restores the register defaults and filter state and empties the output.
module audio_lowpass_dcblock_chain_core #(
    parameter int ADC_BITS = 12,
    localparam int CfgW = (ADC_BITS > 9) ? ADC_BITS : 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [aldc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CfgW-1:0]               cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ADC_BITS-1:0]           s_adc_sample,
    input  logic                          s_restart,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_last
);

    localparam int AW = ADC_BITS + 8;   // low-pass accumulator
    localparam int PW = ADC_BITS + 16;  // low-pass product
    localparam int CW = ADC_BITS + 5;   // centered sample, signed
    localparam int YW = ADC_BITS + 15;  // high-pass output history, signed
    localparam int SW = ADC_BITS + 16;  // high-pass input sum, signed
    localparam int QW = ADC_BITS + 24;  // high-pass product, signed

    // Configuration registers
    logic [aldc_pkg::LP_ALPHA_W-1:0] lp_alpha_reg;
    logic [aldc_pkg::HP_ALPHA_W-1:0] hp_alpha_reg;
    logic [ADC_BITS-1:0]             center_reg;

    // Filter state
    logic [AW-1:0] acc_reg;
    logic [CW-1:0] prev_in_reg;
    logic [YW-1:0] prev_out_reg;

    // Sequencer and serial datapath
    aldc_pkg::state_t state_reg, state_next;
    logic [3:0]                      cnt_reg;
    logic [ADC_BITS-1:0]             x_reg;
    logic [aldc_pkg::LP_ALPHA_W-1:0] a_reg;
    logic [aldc_pkg::LP_ALPHA_W-1:0] b_reg;
    logic [aldc_pkg::HP_ALPHA_W-1:0] h_reg;
    logic [PW-1:0]                   p_reg;
    logic [SW-1:0]                   s_reg;
    logic [QW-1:0]                   q_reg;

    // Output register
    logic [15:0] out_word_reg;
    logic        out_valid_reg;
    logic        out_hi_reg;

    logic                            accept;
    logic                            out_free;
    logic                            load_out;
    logic [aldc_pkg::LP_ALPHA_W-1:0] a_eff;
    logic [PW-1:0]                   p_next;
    logic [ADC_BITS-1:0]             filtered;
    logic [ADC_BITS:0]               diff;
    logic [CW-1:0]                   centered;
    logic [SW-1:0]                   s_next;
    logic [QW-1:0]                   q_next;
    logic [YW-1:0]                   hp;
    logic [YW-16:0]                  hp_top;
    logic [15:0]                     sat_word;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || (m_ready && out_hi_reg);

    // Any alpha at or above unity passes the new sample straight through.
    assign a_eff = lp_alpha_reg[aldc_pkg::LP_ALPHA_W-1] ? aldc_pkg::LP_ALPHA_UNITY
                                                        : lp_alpha_reg;

    // Horner step: doubles the partial mix, then adds x*256 and acc per bit.
    assign p_next = {p_reg[PW-2:0], 1'b0}
                  + (a_reg[aldc_pkg::LP_ALPHA_W-1] ? {{(PW-AW){1'b0}}, x_reg, 8'd0} : '0)
                  + (b_reg[aldc_pkg::LP_ALPHA_W-1] ? {{(PW-AW){1'b0}}, acc_reg} : '0);

    assign filtered = p_reg[PW-1:16];
    assign diff     = {1'b0, filtered} - {1'b0, center_reg};
    assign centered = {diff, 4'd0};
    assign s_next   = {prev_out_reg[YW-1], prev_out_reg}
                    + {{(SW-CW){centered[CW-1]}}, centered}
                    - {{(SW-CW){prev_in_reg[CW-1]}}, prev_in_reg};

    assign q_next = {q_reg[QW-2:0], 1'b0}
                  + (h_reg[aldc_pkg::HP_ALPHA_W-1] ? {{(QW-SW){s_reg[SW-1]}}, s_reg} : '0);

    // Dropping the low 8 bits of the two's complement product floors it.
    assign hp     = q_reg[YW+7:8];
    assign hp_top = hp[YW-1:15];

    always_comb begin
        if ((&hp_top) || !(|hp_top)) begin
            sat_word = hp[15:0];
        end else if (hp[YW-1]) begin
            sat_word = aldc_pkg::SAT_NEG;
        end else begin
            sat_word = aldc_pkg::SAT_POS;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            aldc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = aldc_pkg::ST_LP_MUL;
                end
            end
            aldc_pkg::ST_LP_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = aldc_pkg::ST_HP_SUM;
                end
            end
            aldc_pkg::ST_HP_SUM: begin
                state_next = aldc_pkg::ST_HP_MUL;
            end
            aldc_pkg::ST_HP_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = aldc_pkg::ST_DONE;
                end
            end
            aldc_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = aldc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aldc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aldc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_alpha_reg <= aldc_pkg::LP_ALPHA_RESET;
            hp_alpha_reg <= aldc_pkg::HP_ALPHA_RESET;
            center_reg   <= {1'b1, {(ADC_BITS-1){1'b0}}};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aldc_pkg::REG_LOWPASS_ALPHA:  lp_alpha_reg <= cfg_wdata[aldc_pkg::LP_ALPHA_W-1:0];
                aldc_pkg::REG_HIGHPASS_ALPHA: hp_alpha_reg <= cfg_wdata[aldc_pkg::HP_ALPHA_W-1:0];
                aldc_pkg::REG_ADC_CENTER:     center_reg   <= cfg_wdata[ADC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= {1'b1, {(AW-1){1'b0}}};
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
        end else begin
            if (accept && s_restart) begin
                acc_reg      <= {center_reg, 8'd0};
                prev_in_reg  <= '0;
                prev_out_reg <= '0;
            end
            if (state_reg == aldc_pkg::ST_HP_SUM) begin
                acc_reg     <= p_reg[PW-1:8];
                prev_in_reg <= centered;
            end
            if (load_out) begin
                prev_out_reg <= hp;
            end
        end
    end

    // Serial datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_adc_sample;
            a_reg   <= a_eff;
            b_reg   <= aldc_pkg::LP_ALPHA_UNITY - a_eff;
            p_reg   <= '0;
            cnt_reg <= aldc_pkg::LP_LAST_STEP;
        end
        if (state_reg == aldc_pkg::ST_LP_MUL) begin
            p_reg   <= p_next;
            a_reg   <= {a_reg[aldc_pkg::LP_ALPHA_W-2:0], 1'b0};
            b_reg   <= {b_reg[aldc_pkg::LP_ALPHA_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 4'd1;
        end
        if (state_reg == aldc_pkg::ST_HP_SUM) begin
            s_reg   <= s_next;
            h_reg   <= hp_alpha_reg;
            q_reg   <= '0;
            cnt_reg <= aldc_pkg::HP_LAST_STEP;
        end
        if (state_reg == aldc_pkg::ST_HP_MUL) begin
            q_reg   <= q_next;
            h_reg   <= {h_reg[aldc_pkg::HP_ALPHA_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // Output register: low byte first, then the high byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_hi_reg    <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
            out_hi_reg    <= 1'b0;
        end else if (out_valid_reg && m_ready) begin
            if (out_hi_reg) begin
                out_valid_reg <= 1'b0;
                out_hi_reg    <= 1'b0;
            end else begin
                out_hi_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_word_reg <= sat_word;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_hi_reg ? out_word_reg[15:8] : out_word_reg[7:0];
    assign m_last     = out_hi_reg;

endmodule

FILE: rtl/aldc_checker.sv
// Port-level checker for audio_lowpass_dcblock_chain_core, bound to it below.
// Depends on aldc_pkg for the register index width.
module aldc_checker #(
    parameter int ADC_BITS = 12,
    localparam int CfgW = (ADC_BITS > 9) ? ADC_BITS : 9
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [aldc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [CfgW-1:0]                cfg_wdata,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [ADC_BITS-1:0]            s_adc_sample,
    input logic                           s_restart,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [7:0]                     m_out_byte,
    input logic                           m_last
);

    // A stalled result request keeps its byte and its position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("result request changed while stalled");

    // Once the low byte is taken, the high byte of the same word follows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_last)
        else $error("high byte did not follow the low byte");

    // The block works on one sample at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second sample accepted while busy");

    // Reset empties the output.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result request present after reset");

endmodule

bind audio_lowpass_dcblock_chain_core aldc_checker #(.ADC_BITS(ADC_BITS)) u_aldc_checker (.*);

FILE: bench/tb_audio_lowpass_dcblock_chain_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the microphone low-pass / DC-blocker chain core.
// It predicts each output byte pair from its own copy of the filter state and
// the registers, and it compares them in order. Depends on aldc_pkg and the core.
module tb_audio_lowpass_dcblock_chain_core;

    localparam int ADC_BITS = 12;
    localparam int CFG_W = (ADC_BITS > 9) ? ADC_BITS : 9;
    localparam int LP_ACC_W = ADC_BITS + 8;
    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam longint MIX_UNITY = 256;
    localparam longint WORD_MIN = -32768;
    localparam longint WORD_MAX = 32767;
    localparam logic [aldc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc;
        logic                restart;
    } sample_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SLOW
    } rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [aldc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ADC_BITS-1:0] s_adc_sample = '0;
    logic s_restart = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic m_last;

    // Register shadow and filter state of the predictor.
    logic [aldc_pkg::LP_ALPHA_W-1:0] lp_alpha_shadow = aldc_pkg::LP_ALPHA_RESET;
    logic [aldc_pkg::HP_ALPHA_W-1:0] hp_alpha_shadow = aldc_pkg::HP_ALPHA_RESET;
    logic [ADC_BITS-1:0] center_shadow = ADC_BITS'(1 << (ADC_BITS - 1));
    logic [LP_ACC_W-1:0] lowpass_acc = LP_ACC_W'((1 << (ADC_BITS - 1)) << 8);
    longint dc_prev_in = 0;
    longint dc_prev_out = 0;

    sample_t sample_q[$];
    out_byte_t byte_q[$];
    sample_t next_sample;
    out_byte_t seen_byte;
    logic [15:0] predicted_word;

    int burst_left = 0;
    int gap_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int rx_mode_left = 0;

    int errors = 0;
    int samples_taken = 0;
    int bytes_checked = 0;
    int saturated_words = 0;
    int settings_run = 0;
    int walk_level = 2048;

    audio_lowpass_dcblock_chain_core #(
        .ADC_BITS(ADC_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_adc_sample(s_adc_sample),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One sample through low-pass, centering and DC blocker; returns the
    // saturated 16-bit word and advances the predictor state.
    function automatic logic [15:0] filter_chain_word(input logic [ADC_BITS-1:0] raw,
                                                      input logic restart);
        longint gain;
        longint mix;
        longint centered;
        longint dc_out;
        logic [15:0] word;
        if (restart) begin
            lowpass_acc = {center_shadow, 8'd0};
            dc_prev_in = 0;
            dc_prev_out = 0;
        end
        gain = (lp_alpha_shadow > aldc_pkg::LP_ALPHA_UNITY) ? MIX_UNITY
                                                             : longint'(lp_alpha_shadow);
        mix = gain * (longint'(raw) << 8) + (MIX_UNITY - gain) * longint'(lowpass_acc);
        lowpass_acc = LP_ACC_W'(mix >>> 8);
        centered = (longint'(lowpass_acc[LP_ACC_W-1:8]) - longint'(center_shadow)) * 16;
        // Arithmetic shifts floor toward minus infinity, as the block does.
        dc_out = (longint'(hp_alpha_shadow) * (dc_prev_out + centered - dc_prev_in)) >>> 8;
        dc_prev_in = centered;
        dc_prev_out = dc_out;
        if (dc_out < WORD_MIN) begin
            word = aldc_pkg::SAT_NEG;
            saturated_words++;
        end else if (dc_out > WORD_MAX) begin
            word = aldc_pkg::SAT_POS;
            saturated_words++;
        end else begin
            word = dc_out[15:0];
        end
        return word;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (s_valid && !s_ready) begin
            // The request waits with its payload unchanged.
        end else if (gap_left != 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
            next_sample = sample_q.pop_front();
            s_valid <= 1'b1;
            s_adc_sample <= next_sample.adc;
            s_restart <= next_sample.restart;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                case ($urandom_range(0, 9))
                    0, 1, 2: gap_left <= 0;
                    3, 4, 5, 6, 7: gap_left <= $urandom_range(1, 8);
                    default: gap_left <= $urandom_range(9, 60);
                endcase
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: stall pattern that switches between free-running, random and slow.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode <= RX_FREE;
            rx_mode_left <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_mode_left <= $urandom_range(20, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_FREE: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Prediction on accepted samples and in-order checking of output bytes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_word = filter_chain_word(s_adc_sample, s_restart);
                byte_q.push_back('{data: predicted_word[7:0], last: 1'b0});
                byte_q.push_back('{data: predicted_word[15:8], last: 1'b1});
                samples_taken++;
            end
            if (m_valid && m_ready) begin
                if (byte_q.size() == 0) begin
                    $display("%0t: output byte %02h last %0b with nothing expected",
                             $time, m_out_byte, m_last);
                    errors++;
                end else begin
                    seen_byte = byte_q.pop_front();
                    bytes_checked++;
                    if (m_out_byte !== seen_byte.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, seen_byte.data, m_out_byte);
                        errors++;
                    end
                    if (m_last !== seen_byte.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, seen_byte.last, m_last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [aldc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            aldc_pkg::REG_LOWPASS_ALPHA:
                lp_alpha_shadow = data[aldc_pkg::LP_ALPHA_W-1:0];
            aldc_pkg::REG_HIGHPASS_ALPHA:
                hp_alpha_shadow = data[aldc_pkg::HP_ALPHA_W-1:0];
            aldc_pkg::REG_ADC_CENTER: center_shadow = data[ADC_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input int adc, input logic restart);
        sample_q.push_back('{adc: adc[ADC_BITS-1:0], restart: restart});
    endtask

    // Waits until every queued sample went in and every byte came out, then
    // lets the pipeline settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_valid || byte_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        settings_run++;
    endtask

    // Mostly a slowly wandering signal like real audio, with noise and
    // rail-to-rail jumps mixed in; restarts are rare.
    task automatic push_random_samples(input int count);
        int adc;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    walk_level += int'($urandom_range(0, 400)) - 200;
                    if (walk_level < 0) walk_level = 0;
                    if (walk_level > ADC_MAX) walk_level = ADC_MAX;
                    adc = walk_level;
                end
                12, 13, 14, 15, 16: adc = $urandom_range(0, ADC_MAX);
                17, 18: adc = ($urandom_range(0, 1) != 0) ? ADC_MAX : 0;
                default: adc = int'(center_shadow);
            endcase
            push_sample(adc, $urandom_range(0, 49) == 0);
        end
    endtask

    task automatic write_random_settings();
        int lp;
        int hp;
        int mid;
        case ($urandom_range(0, 4))
            0: lp = 0;
            1: lp = int'(aldc_pkg::LP_ALPHA_UNITY);
            2: lp = $urandom_range(257, 511);
            default: lp = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 4))
            0: hp = 0;
            1: hp = 255;
            default: hp = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 4))
            0: mid = 0;
            1: mid = ADC_MAX;
            default: mid = $urandom_range(0, ADC_MAX);
        endcase
        cfg_write(aldc_pkg::REG_LOWPASS_ALPHA, CFG_W'(lp));
        cfg_write(aldc_pkg::REG_HIGHPASS_ALPHA, CFG_W'(hp));
        // The midpoint changes without a restart most of the time, so the
        // low-pass keeps its old accumulator.
        cfg_write(aldc_pkg::REG_ADC_CENTER, CFG_W'(mid));
        if ($urandom_range(0, 2) == 0)
            cfg_write(REG_UNUSED, CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: extremes, bit patterns and a restart in the middle.
        push_sample(2048, 1'b0);
        push_sample(ADC_MAX, 1'b0);
        push_sample(0, 1'b0);
        push_sample(12'hAAA, 1'b0);
        push_sample(12'h555, 1'b0);
        push_sample(ADC_MAX, 1'b1);
        push_sample(0, 1'b0);
        wait_idle();

        // Unfiltered low-pass and the strongest DC blocker: alternating rails
        // swing the output across nearly the full signed 16-bit range.
        cfg_write(aldc_pkg::REG_LOWPASS_ALPHA, CFG_W'(aldc_pkg::LP_ALPHA_UNITY));
        cfg_write(aldc_pkg::REG_HIGHPASS_ALPHA, CFG_W'(255));
        push_sample(2048, 1'b1);
        for (int n = 0; n < 8; n++)
            push_sample((n % 2 == 0) ? ADC_MAX : 0, 1'b0);
        wait_idle();

        // Low-pass alpha above unity, DC blocker off, midpoint at zero.
        cfg_write(aldc_pkg::REG_LOWPASS_ALPHA, CFG_W'(511));
        cfg_write(aldc_pkg::REG_HIGHPASS_ALPHA, CFG_W'(0));
        cfg_write(aldc_pkg::REG_ADC_CENTER, CFG_W'(0));
        push_sample(ADC_MAX, 1'b0);
        push_sample(0, 1'b0);
        push_sample(1234, 1'b1);
        wait_idle();

        // Frozen low-pass, midpoint at the top; the unused index must be ignored.
        cfg_write(aldc_pkg::REG_LOWPASS_ALPHA, CFG_W'(0));
        cfg_write(aldc_pkg::REG_HIGHPASS_ALPHA, CFG_W'(128));
        cfg_write(aldc_pkg::REG_ADC_CENTER, CFG_W'(ADC_MAX));
        cfg_write(REG_UNUSED, {CFG_W{1'b1}});
        push_sample(0, 1'b0);
        push_sample(ADC_MAX, 1'b1);
        push_sample(0, 1'b0);
        push_sample(2048, 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_random_settings();
            push_random_samples(ITEMS_PER_PHASE);
            wait_idle();
        end

        $display("Ran %0d samples under %0d register settings, %0d bytes checked.",
                 samples_taken, settings_run, bytes_checked);
        $display("%0d predicted words hit the saturation limits.", saturated_words);
        if (errors == 0 && byte_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
